>>> rtl/core/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and init tables of the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_INSTR  = 3'd1,
        CMD_DATA   = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_INIT   = 3'd5
    } t_cmd;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_HOLD  = 9'b000000010,
        PH_HI1   = 9'b000000100,
        PH_LO1   = 9'b000001000,
        PH_HI2   = 9'b000010000,
        PH_LO2   = 9'b000100000,
        PH_WAIT  = 9'b001000000,
        PH_EXTRA = 9'b010000000,
        PH_NWAIT = 9'b100000000
    } t_phase;

    localparam logic [1:0] REG_ENABLE_WIDTH = 2'd0;
    localparam logic [1:0] REG_INSTR_WAIT   = 2'd1;
    localparam logic [1:0] REG_DATA_WAIT    = 2'd2;

    localparam logic [7:0]  ENABLE_WIDTH_RST = 8'd2;
    localparam logic [15:0] INSTR_WAIT_RST   = 16'd2000;
    localparam logic [15:0] DATA_WAIT_RST    = 16'd50;

    localparam logic [15:0] HOLD_TICKS   = 16'd20000;
    localparam logic [11:0] CLEAR_EXTRA  = 12'd2000;
    localparam logic [7:0]  CLEAR_INSTR  = 8'h01;
    localparam logic [7:0]  ROW0_ADDR    = 8'h80;
    localparam logic [7:0]  ROW1_ADDR    = 8'hC0;

    localparam logic [3:0] STEP_NONE      = 4'd0;
    localparam logic [3:0] STEP_NIB_FIRST = 4'd1;
    localparam logic [3:0] STEP_NIB_LAST  = 4'd4;
    localparam logic [3:0] STEP_INS_FIRST = 4'd5;
    localparam logic [3:0] STEP_INS_LAST  = 4'd8;

    typedef struct packed {
        logic [7:0]  enable_width;
        logic [15:0] instr_wait;
        logic [15:0] data_wait;
    } t_cfg;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nibble;
        logic       busy;
        logic       rejected;
    } t_result;

    function automatic logic [3:0] init_nibble(input logic [1:0] idx);
        case (idx)
            2'd3:    init_nibble = 4'h2;
            default: init_nibble = 4'h3;
        endcase
    endfunction

    function automatic logic [15:0] init_nwait(input logic [1:0] idx);
        case (idx)
            2'd1:    init_nwait = 16'd150;
            default: init_nwait = 16'd5000;
        endcase
    endfunction

    function automatic logic [7:0] init_instr(input logic [1:0] idx);
        case (idx)
            2'd0:    init_instr = 8'h28;
            2'd1:    init_instr = 8'h0C;
            2'd2:    init_instr = 8'h01;
            default: init_instr = 8'h06;
        endcase
    endfunction

    function automatic logic [11:0] init_extra(input logic [1:0] idx);
        case (idx)
            2'd2:    init_extra = 12'd2000;
            default: init_extra = 12'd1000;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/clcd_seq.sv
// ----------------------------------------------------------------------------
// clcd_seq
// Pin sequencer: holds the phase state and computes the pin levels and
// status for each accepted word in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [2:0]       i_command,
    input  wire logic [7:0]       i_value,
    input  wire logic [5:0]       i_column,
    input  wire logic             i_row,
    input  wire clcd_pkg::t_cfg   i_cfg,
    output clcd_pkg::t_result     o_result
);
    import clcd_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_init_step, n_init_step;
    logic [15:0] r_wait,      n_wait;
    logic [7:0]  r_byte,      n_byte;
    logic [11:0] r_extra,     n_extra;
    logic        r_rs,        n_rs;
    logic        r_en,        n_en;
    logic [3:0]  r_nib,       n_nib;

    logic        w_rejected;
    logic        w_do_start;
    logic        w_start_rs;
    logic [7:0]  w_start_byte;
    logic [11:0] w_start_extra;
    logic        w_do_nib;
    logic        w_do_finish;
    logic [15:0] w_wc_dec;
    logic [11:0] w_ex_dec;
    logic [15:0] w_ew;
    logic [15:0] w_byte_wait;
    logic        w_in_nib_step;
    logic        w_in_ins_step;

    assign w_wc_dec = (r_wait != '0) ? r_wait - 16'd1 : '0;
    assign w_ex_dec = (r_extra != '0) ? r_extra - 12'd1 : '0;
    assign w_ew     = (i_cfg.enable_width == '0) ? 16'd1 : {8'd0, i_cfg.enable_width};
    assign w_byte_wait = r_rs ? ((i_cfg.data_wait == '0) ? 16'd1 : i_cfg.data_wait)
                              : ((i_cfg.instr_wait == '0) ? 16'd1 : i_cfg.instr_wait);
    assign w_in_nib_step = (r_init_step >= STEP_NIB_FIRST) && (r_init_step <= STEP_NIB_LAST);
    assign w_in_ins_step = (r_init_step >= STEP_INS_FIRST) && (r_init_step < STEP_INS_LAST);

    always_comb begin
        n_phase       = r_phase;
        n_init_step   = r_init_step;
        n_wait        = r_wait;
        n_byte        = r_byte;
        n_extra       = r_extra;
        n_rs          = r_rs;
        n_en          = r_en;
        n_nib         = r_nib;
        w_rejected    = 1'b0;
        w_do_start    = 1'b0;
        w_start_rs    = 1'b0;
        w_start_byte  = '0;
        w_start_extra = '0;
        w_do_nib      = 1'b0;
        w_do_finish   = 1'b0;

        if (i_accept) begin
            case (t_cmd'(i_command)) inside
                CMD_TICK: begin
                    if (r_phase == PH_EXTRA) begin
                        n_extra = w_ex_dec;
                        if (w_ex_dec == '0) begin
                            w_do_finish = 1'b1;
                        end
                    end else if (r_phase != PH_IDLE) begin
                        n_wait = w_wc_dec;
                        if (w_wc_dec == '0) begin
                            unique case (r_phase)
                                PH_HOLD: begin
                                    n_init_step = STEP_NIB_FIRST;
                                    w_do_nib    = 1'b1;
                                end
                                PH_HI1: begin
                                    n_en    = 1'b0;
                                    n_wait  = w_ew;
                                    n_phase = PH_LO1;
                                end
                                PH_LO1: begin
                                    if (w_in_nib_step) begin
                                        n_wait  = init_nwait(2'(r_init_step - 4'd1));
                                        n_phase = PH_NWAIT;
                                    end else begin
                                        n_nib   = r_byte[3:0];
                                        n_en    = 1'b1;
                                        n_wait  = w_ew;
                                        n_phase = PH_HI2;
                                    end
                                end
                                PH_HI2: begin
                                    n_en    = 1'b0;
                                    n_wait  = w_ew;
                                    n_phase = PH_LO2;
                                end
                                PH_LO2: begin
                                    n_wait  = w_byte_wait;
                                    n_phase = PH_WAIT;
                                end
                                PH_WAIT: begin
                                    if (r_extra != '0) begin
                                        n_phase = PH_EXTRA;
                                    end else begin
                                        w_do_finish = 1'b1;
                                    end
                                end
                                PH_NWAIT: begin
                                    if (r_init_step < STEP_NIB_LAST) begin
                                        n_init_step = r_init_step + 4'd1;
                                        w_do_nib    = 1'b1;
                                    end else begin
                                        n_init_step   = STEP_INS_FIRST;
                                        w_do_start    = 1'b1;
                                        w_start_byte  = init_instr(2'd0);
                                        w_start_extra = init_extra(2'd0);
                                    end
                                end
                                default: begin
                                    n_init_step = STEP_NONE;
                                    n_phase     = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                CMD_INSTR, CMD_DATA, CMD_CURSOR, CMD_CLEAR, CMD_INIT: begin
                    if (r_phase != PH_IDLE) begin
                        w_rejected = 1'b1;
                    end else begin
                        unique case (t_cmd'(i_command))
                            CMD_INSTR: begin
                                w_do_start   = 1'b1;
                                w_start_byte = i_value;
                            end
                            CMD_DATA: begin
                                w_do_start   = 1'b1;
                                w_start_rs   = 1'b1;
                                w_start_byte = i_value;
                            end
                            CMD_CURSOR: begin
                                w_do_start   = 1'b1;
                                w_start_byte = (i_row ? ROW1_ADDR : ROW0_ADDR)
                                               + {2'd0, i_column};
                            end
                            CMD_CLEAR: begin
                                w_do_start    = 1'b1;
                                w_start_byte  = CLEAR_INSTR;
                                w_start_extra = CLEAR_EXTRA;
                            end
                            default: begin
                                n_rs        = 1'b0;
                                n_en        = 1'b0;
                                n_nib       = '0;
                                n_init_step = STEP_NONE;
                                n_wait      = HOLD_TICKS;
                                n_phase     = PH_HOLD;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_do_finish) begin
            if (w_in_ins_step) begin
                n_init_step   = r_init_step + 4'd1;
                w_do_start    = 1'b1;
                w_start_byte  = init_instr(2'(r_init_step - STEP_NIB_LAST));
                w_start_extra = init_extra(2'(r_init_step - STEP_NIB_LAST));
            end else begin
                n_init_step = STEP_NONE;
                n_phase     = PH_IDLE;
            end
        end

        if (w_do_nib) begin
            n_rs    = 1'b0;
            n_nib   = init_nibble(2'(n_init_step - 4'd1));
            n_en    = 1'b1;
            n_wait  = w_ew;
            n_phase = PH_HI1;
        end

        if (w_do_start) begin
            n_rs    = w_start_rs;
            n_byte  = w_start_byte;
            n_extra = w_start_extra;
            n_nib   = w_start_byte[7:4];
            n_en    = 1'b1;
            n_wait  = w_ew;
            n_phase = PH_HI1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_init_step <= STEP_NONE;
            r_wait      <= '0;
            r_byte      <= '0;
            r_extra     <= '0;
            r_rs        <= 1'b0;
            r_en        <= 1'b0;
            r_nib       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_init_step <= n_init_step;
            r_wait      <= n_wait;
            r_byte      <= n_byte;
            r_extra     <= n_extra;
            r_rs        <= n_rs;
            r_en        <= n_en;
            r_nib       <= n_nib;
        end
    end

    always_comb begin
        o_result.rs       = n_rs;
        o_result.en       = n_en;
        o_result.nibble   = n_nib;
        o_result.busy     = (n_phase != PH_IDLE);
        o_result.rejected = w_rejected;
    end

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_4bit_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface
// HD44780-style character LCD driver on a 4-bit bus, with APB registers.
// ----------------------------------------------------------------------------
// Each input word is a one-microsecond tick or a request (instruction, data,
// cursor move, clear, init) and yields one result word with the pin levels
// and busy/rejected status after it. One word is accepted per clock cycle
// while o_stall is low; its result is registered, as the sequencer computes
// the next state and pins in a single pass. A two-entry output buffer keeps
// taking words while a result waits; o_stall rises only when both entries
// are full. Registers: 0x0 enable width, 0x4 instruction wait, 0x8 data
// wait, all in ticks.
`default_nettype none

module char_lcd_4bit_interface (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_value,
    input  wire logic [5:0]  i_column,
    input  wire logic        i_row,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_rs_pin,
    output logic             o_en_pin,
    output logic [3:0]       o_bus_nibble,
    output logic             o_busy_res,
    output logic             o_rejected,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import clcd_pkg::*;

    logic [7:0]  r_enable_width;
    logic [15:0] r_instr_wait;
    logic [15:0] r_data_wait;
    t_cfg        w_cfg;
    logic        w_cfg_write;

    logic        w_accept;
    logic        w_take;
    t_result     w_result;
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_width <= ENABLE_WIDTH_RST;
            r_instr_wait   <= INSTR_WAIT_RST;
            r_data_wait    <= DATA_WAIT_RST;
        end else if (w_cfg_write) begin
            unique case (paddr[3:2])
                REG_ENABLE_WIDTH: r_enable_width <= pwdata[7:0];
                REG_INSTR_WAIT:   r_instr_wait   <= pwdata[15:0];
                REG_DATA_WAIT:    r_data_wait    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENABLE_WIDTH: prdata = {24'd0, r_enable_width};
            REG_INSTR_WAIT:   prdata = {16'd0, r_instr_wait};
            REG_DATA_WAIT:    prdata = {16'd0, r_data_wait};
            default:          prdata = '0;
        endcase
    end

    assign w_cfg.enable_width = r_enable_width;
    assign w_cfg.instr_wait   = r_instr_wait;
    assign w_cfg.data_wait    = r_data_wait;

    assign o_stall  = r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign w_take   = r_out_valid && !i_stall;

    clcd_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_command (i_command),
        .i_value   (i_value),
        .i_column  (i_column),
        .i_row     (i_row),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    // hold a result in the skid entry while the output word is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_rs_pin     = r_out.rs;
    assign o_en_pin     = r_out.en;
    assign o_bus_nibble = r_out.nibble;
    assign o_busy_res   = r_out.busy;
    assign o_rejected   = r_out.rejected;

endmodule

`default_nettype wire

>>> rtl/core/clcd_chk.sv
// ----------------------------------------------------------------------------
// clcd_chk
// Port-level checks of the LCD interface, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_en_pin,
    input wire logic o_busy_res,
    input wire logic o_rejected,
    input wire logic pready
);

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_busy_res)
        else $error("rejected word without busy");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_en_pin |-> o_busy_res)
        else $error("enable strobe high while idle");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !(o_valid && i_stall) |=> o_valid)
        else $error("accepted word did not reach the output");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without output backpressure");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind char_lcd_4bit_interface clcd_chk u_chk (.*);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
// A local sequencer tracks the phase, step, counters and pin levels of the
// LCD driver and works out the pin/busy/rejected word that each accepted
// input word must produce. Named tasks cover idle words, default, zero and
// extreme timing, cursor moves, clear, power-up init and back-pressure, then
// random sequences of requests, ticks, rejected requests and unused codes
// under several timing settings. Timing registers are written over APB only
// when no result word is outstanding, and read back.
// ----------------------------------------------------------------------------

module tb_top;

    import clcd_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 2_000_000;
    localparam int unsigned RANDOM_ITEMS    = 1550;
    localparam int unsigned HOLD_OFF_CYCLES = 300;

    localparam logic [2:0] CMD_UNUSED6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED7 = 3'd7;

    localparam logic [7:0]  DEF_ENABLE_WIDTH = 8'd2;
    localparam logic [15:0] DEF_INSTR_WAIT   = 16'd2000;
    localparam logic [15:0] DEF_DATA_WAIT    = 16'd50;

    localparam logic [15:0] POWER_HOLD  = 16'd20000;
    localparam logic [11:0] CLEAR_WAIT  = 12'd2000;
    localparam logic [7:0]  CLEAR_BYTE  = 8'h01;
    localparam logic [7:0]  ROW0_BASE   = 8'h80;
    localparam logic [7:0]  ROW1_BASE   = 8'hC0;

    localparam logic [3:0] SEQ_NONE  = 4'd0;
    localparam logic [3:0] NIB_FIRST = 4'd1;
    localparam logic [3:0] NIB_LAST  = 4'd4;
    localparam logic [3:0] INS_FIRST = 4'd5;
    localparam logic [3:0] INS_LAST  = 4'd8;

    localparam logic [3:0][3:0]  INIT_NIB   = {4'h2, 4'h3, 4'h3, 4'h3};
    localparam logic [3:0][15:0] INIT_NWAIT = {16'd5000, 16'd5000, 16'd150, 16'd5000};
    localparam logic [3:0][7:0]  INIT_INS   = {8'h06, 8'h01, 8'h0C, 8'h28};
    localparam logic [3:0][11:0] INIT_EXTRA = {12'd1000, 12'd2000, 12'd1000, 12'd1000};

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [2:0]  i_command = 3'd0;
    logic [7:0]  i_value   = 8'd0;
    logic [5:0]  i_column  = 6'd0;
    logic        i_row     = 1'b0;
    logic        i_stall   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = 4'd0;
    logic [31:0] pwdata    = 32'd0;
    logic        o_stall;
    logic        o_valid;
    logic        o_rs_pin;
    logic        o_en_pin;
    logic [3:0]  o_bus_nibble;
    logic        o_busy_res;
    logic        o_rejected;
    logic [31:0] prdata;
    logic        pready;

    t_phase      lcd_phase;
    logic [3:0]  seq_step;
    logic [15:0] tick_left;
    logic [7:0]  byte_hold;
    logic [11:0] extra_left;
    logic        rs_lvl;
    logic        en_lvl;
    logic [3:0]  nib_lvl;
    t_cfg        timing;

    t_result     pin_levels_q[$];
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    bit          tx_steady    = 1'b0;
    bit          rx_steady    = 1'b0;
    bit          hold_off_req = 1'b0;

    char_lcd_4bit_interface u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rs_pin     (o_rs_pin),
        .o_en_pin     (o_en_pin),
        .o_bus_nibble (o_bus_nibble),
        .o_busy_res   (o_busy_res),
        .o_rejected   (o_rejected),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------------
    function automatic logic [15:0] nonzero_ticks(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic void start_byte(input logic rs, input logic [7:0] b,
                                       input logic [11:0] extra);
        rs_lvl     = rs;
        byte_hold  = b;
        extra_left = extra;
        nib_lvl    = b[7:4];
        en_lvl     = 1'b1;
        tick_left  = nonzero_ticks({8'd0, timing.enable_width});
        lcd_phase  = PH_HI1;
    endfunction

    function automatic void start_init_nibble();
        logic [1:0] idx;
        idx       = seq_step[1:0] - 2'd1;
        rs_lvl    = 1'b0;
        nib_lvl   = INIT_NIB[idx];
        en_lvl    = 1'b1;
        tick_left = nonzero_ticks({8'd0, timing.enable_width});
        lcd_phase = PH_HI1;
    endfunction

    function automatic void finish_byte();
        logic [1:0] idx;
        if (seq_step >= INS_FIRST && seq_step < INS_LAST) begin
            seq_step = seq_step + 4'd1;
            idx      = seq_step[1:0] - 2'd1;
            start_byte(1'b0, INIT_INS[idx], INIT_EXTRA[idx]);
        end else begin
            seq_step  = SEQ_NONE;
            lcd_phase = PH_IDLE;
        end
    endfunction

    function automatic void lcd_tick();
        logic [1:0] idx;
        if (lcd_phase == PH_IDLE) return;
        if (lcd_phase == PH_EXTRA) begin
            if (extra_left != 12'd0) extra_left = extra_left - 12'd1;
            if (extra_left == 12'd0) finish_byte();
            return;
        end
        if (tick_left != 16'd0) tick_left = tick_left - 16'd1;
        if (tick_left != 16'd0) return;
        idx = seq_step[1:0] - 2'd1;
        case (lcd_phase)
            PH_HOLD: begin
                seq_step = NIB_FIRST;
                start_init_nibble();
            end
            PH_HI1: begin
                en_lvl    = 1'b0;
                tick_left = nonzero_ticks({8'd0, timing.enable_width});
                lcd_phase = PH_LO1;
            end
            PH_LO1: begin
                if (seq_step >= NIB_FIRST && seq_step <= NIB_LAST) begin
                    tick_left = INIT_NWAIT[idx];
                    lcd_phase = PH_NWAIT;
                end else begin
                    nib_lvl   = byte_hold[3:0];
                    en_lvl    = 1'b1;
                    tick_left = nonzero_ticks({8'd0, timing.enable_width});
                    lcd_phase = PH_HI2;
                end
            end
            PH_HI2: begin
                en_lvl    = 1'b0;
                tick_left = nonzero_ticks({8'd0, timing.enable_width});
                lcd_phase = PH_LO2;
            end
            PH_LO2: begin
                tick_left = nonzero_ticks(rs_lvl ? timing.data_wait : timing.instr_wait);
                lcd_phase = PH_WAIT;
            end
            PH_WAIT: begin
                if (extra_left != 12'd0) lcd_phase = PH_EXTRA;
                else finish_byte();
            end
            PH_NWAIT: begin
                seq_step = seq_step + 4'd1;
                if (seq_step <= NIB_LAST) begin
                    start_init_nibble();
                end else begin
                    seq_step = INS_FIRST;
                    start_byte(1'b0, INIT_INS[0], INIT_EXTRA[0]);
                end
            end
            default: begin
                seq_step  = SEQ_NONE;
                lcd_phase = PH_IDLE;
            end
        endcase
    endfunction

    function automatic t_result advance_lcd(input logic [2:0] cmd, input logic [7:0] val,
                                            input logic [5:0] col, input logic row);
        t_result    r;
        logic       busy;
        logic [7:0] base;
        busy       = (lcd_phase != PH_IDLE);
        r.rejected = 1'b0;
        if (cmd == CMD_TICK) begin
            lcd_tick();
        end else if (cmd <= CMD_INIT) begin
            if (busy) begin
                r.rejected = 1'b1;
            end else begin
                case (cmd)
                    CMD_INSTR:  start_byte(1'b0, val, 12'd0);
                    CMD_DATA:   start_byte(1'b1, val, 12'd0);
                    CMD_CURSOR: begin
                        base = row ? ROW1_BASE : ROW0_BASE;
                        start_byte(1'b0, base + {2'b00, col}, 12'd0);
                    end
                    CMD_CLEAR:  start_byte(1'b0, CLEAR_BYTE, CLEAR_WAIT);
                    default: begin
                        rs_lvl    = 1'b0;
                        en_lvl    = 1'b0;
                        nib_lvl   = 4'd0;
                        seq_step  = SEQ_NONE;
                        tick_left = POWER_HOLD;
                        lcd_phase = PH_HOLD;
                    end
                endcase
            end
        end
        r.rs     = rs_lvl;
        r.en     = en_lvl;
        r.nibble = nib_lvl;
        r.busy   = (lcd_phase != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] val,
                             input logic [5:0] col, input logic row);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        i_column  <= col;
        i_row     <= row;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pin_levels_q.push_back(advance_lcd(cmd, val, col, row));
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_word(cmd, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (pin_levels_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic flag_error(input string what, input int want, input int got);
        err_count++;
        if (err_count <= 10)
            $display("tb_top: mismatch %s: expected %0d, actual %0d", what, want, got);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_ENABLE_WIDTH: timing.enable_width = data[7:0];
            REG_INSTR_WAIT:   timing.instr_wait   = data[15:0];
            default:          timing.data_wait    = data[15:0];
        endcase
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata != data) flag_error("register readback", int'(data), int'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timing(input logic [7:0] width, input logic [15:0] instr_wait,
                              input logic [15:0] data_wait);
        wait_results();
        reg_write(REG_ENABLE_WIDTH, {24'd0, width});
        reg_write(REG_INSTR_WAIT, {16'd0, instr_wait});
        reg_write(REG_DATA_WAIT, {16'd0, data_wait});
    endtask

    task automatic tick_to_idle(input bit steady);
        tx_steady = steady;
        rx_steady = steady;
        while (lcd_phase != PH_IDLE) send_cmd(CMD_TICK);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                gap          = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (rx_steady) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 13);
            end
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) flag_error(name, want, got);
    endtask

    always @(posedge i_clk) begin : pin_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pin_levels_q.size() == 0) begin
                flag_error("result word with none pending", 0, 1);
            end else begin
                want = pin_levels_q.pop_front();
                check_field("rs_pin", int'(want.rs), int'(o_rs_pin));
                check_field("en_pin", int'(want.en), int'(o_en_pin));
                check_field("bus_nibble", int'(want.nibble), int'(o_bus_nibble));
                check_field("busy_res", int'(want.busy), int'(o_busy_res));
                check_field("rejected", int'(want.rejected), int'(o_rejected));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_idle_words();
        send_cmd(CMD_TICK);
        send_cmd(CMD_UNUSED6);
        send_cmd(CMD_UNUSED7);
    endtask

    task automatic test_default_timing();
        send_word(CMD_INSTR, 8'hFF, 6'd0, 1'b0);
        send_cmd(CMD_TICK);
        send_word(CMD_DATA, 8'hAA, 6'd63, 1'b1);
        send_cmd(CMD_INIT);
        send_cmd(CMD_UNUSED7);
        tick_to_idle(1'b1);
        send_word(CMD_DATA, 8'h00, 6'd0, 1'b0);
        tick_to_idle(1'b1);
    endtask

    task automatic test_zero_timing();
        set_timing(8'd0, 16'd0, 16'd0);
        send_word(CMD_INSTR, 8'h5A, 6'd21, 1'b1);
        tick_to_idle(1'b0);
        send_word(CMD_DATA, 8'hA5, 6'd42, 1'b0);
        tick_to_idle(1'b0);
    endtask

    task automatic test_cursor_moves();
        set_timing(8'd1, 16'd3, 16'd2);
        send_word(CMD_CURSOR, 8'hFF, 6'd0, 1'b0);
        send_cmd(CMD_CURSOR);
        tick_to_idle(1'b0);
        send_word(CMD_CURSOR, 8'h00, 6'd63, 1'b1);
        send_cmd(CMD_TICK);
        send_cmd(CMD_CLEAR);
        tick_to_idle(1'b0);
    endtask

    task automatic test_clear();
        set_timing(8'd3, 16'd5, 16'd5);
        send_cmd(CMD_CLEAR);
        send_cmd(CMD_TICK);
        send_cmd(CMD_CLEAR);
        tick_to_idle(1'b1);
    endtask

    task automatic test_power_up_init();
        set_timing(8'd1, 16'd1, 16'd1);
        send_cmd(CMD_INIT);
        repeat (3) send_cmd(CMD_TICK);
        send_cmd(CMD_INSTR);
        send_cmd(CMD_DATA);
        tick_to_idle(1'b1);
    endtask

    task automatic test_extreme_timing();
        set_timing(8'd255, 16'd65535, 16'd65535);
        send_word(CMD_INSTR, 8'h80, 6'd1, 1'b0);
        tick_to_idle(1'b1);
        send_word(CMD_DATA, 8'hFF, 6'd62, 1'b1);
        tick_to_idle(1'b1);
    endtask

    task automatic test_back_pressure();
        int k;
        set_timing(8'd1, 16'd2, 16'd2);
        hold_off_req = 1'b1;
        tx_steady    = 1'b1;
        for (k = 0; k < 48; k++) begin
            if (lcd_phase == PH_IDLE) send_cmd(CMD_DATA);
            else send_cmd(CMD_TICK);
        end
        tx_steady = 1'b0;
        tick_to_idle(1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned pass_n;
        int unsigned done_items;
        int unsigned pick;
        logic [2:0]  code;
        for (pass_n = 0; pass_n < 5; pass_n++) begin
            set_timing(8'($urandom_range(0, 4)), 16'($urandom_range(0, 24)),
                       16'($urandom_range(0, 24)));
            done_items = 0;
            while (done_items < RANDOM_ITEMS / 5) begin
                pick = $urandom_range(0, 99);
                if (lcd_phase == PH_IDLE) begin
                    if (pick < 8) begin
                        send_cmd(CMD_TICK);
                    end else if (pick < 14) begin
                        send_cmd(pick[0] ? CMD_UNUSED6 : CMD_UNUSED7);
                    end else begin
                        code = 3'($urandom_range(1, 3));
                        send_cmd(code);
                        done_items++;
                    end
                end else begin
                    if (pick < 82) begin
                        send_cmd(CMD_TICK);
                        done_items++;
                    end else if (pick < 95) begin
                        code = 3'($urandom_range(1, 5));
                        send_cmd(code);
                        done_items++;
                    end else begin
                        send_cmd(pick[0] ? CMD_UNUSED6 : CMD_UNUSED7);
                    end
                end
            end
            tick_to_idle(1'b0);
        end
    endtask

    initial begin
        lcd_phase           = PH_IDLE;
        seq_step            = SEQ_NONE;
        tick_left           = 16'd0;
        byte_hold           = 8'd0;
        extra_left          = 12'd0;
        rs_lvl              = 1'b0;
        en_lvl              = 1'b0;
        nib_lvl             = 4'd0;
        timing.enable_width = DEF_ENABLE_WIDTH;
        timing.instr_wait   = DEF_INSTR_WAIT;
        timing.data_wait    = DEF_DATA_WAIT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_words();
        test_default_timing();
        test_zero_timing();
        test_cursor_moves();
        test_clear();
        test_power_up_init();
        test_extreme_timing();
        test_back_pressure();
        test_random_traffic();

        wait_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
